/* rtl/kms_pkg.sv */
// Shared types and constants for the kernel match and scale fit block.
package kms_pkg;
	localparam int TAPS = 9;
	localparam int ELEM_W = 16;
	localparam int DOT_W = 37;
	localparam int SLOT_W = 12;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [TAPS-1:0] elem_vec_t;
endpackage

/* rtl/kms_dot9.sv */
// Registered nine-tap dot product of a patch against one stored kernel.
module kms_dot9 (
	input  logic                              clk,
	input  kms_pkg::elem_vec_t                patch,
	input  kms_pkg::elem_vec_t                coef,
	output logic signed [kms_pkg::DOT_W-1:0]  dot
);
	import kms_pkg::*;

	logic signed [31:0] prod_s1 [TAPS];
	logic signed [DOT_W-1:0] sum;

	// Products are registered before the adder tree.
	always_ff @(posedge clk) begin
		for (int t = 0; t < TAPS; t++) begin
			prod_s1[t] <= patch[t] * coef[t];
		end
	end

	always_comb begin
		sum = '0;
		for (int t = 0; t < TAPS; t++) begin
			sum = sum + DOT_W'(prod_s1[t]);
		end
	end

	always_ff @(posedge clk) begin
		dot <= sum;
	end
endmodule

/* rtl/kernel_match_scale_fit.sv */
// Kernel table with a best-match query that scans every stored kernel.
// A load beat writes one table row. A query, once accepted, reads one kernel row per cycle,
// drains the read, product and compare pipeline, reads the inverse norm, does the scale
// multiply and registers its result in the output state, which can stall on out_ready.
// A skipped query (negative first sample) goes straight to the output state.
// Input is taken again once a result is registered. Reset clears control state only.
module kernel_match_scale_fit #(
	parameter int KERNEL_COUNT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [kms_pkg::SLOT_W-1:0]    kernel_slot,
	input  logic signed [15:0]            elem_0,
	input  logic signed [15:0]            elem_1,
	input  logic signed [15:0]            elem_2,
	input  logic signed [15:0]            elem_3,
	input  logic signed [15:0]            elem_4,
	input  logic signed [15:0]            elem_5,
	input  logic signed [15:0]            elem_6,
	input  logic signed [15:0]            elem_7,
	input  logic signed [15:0]            elem_8,
	input  logic [15:0]                   inverse_norm,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          match_valid,
	output logic [kms_pkg::SLOT_W-1:0]    best_kernel,
	output logic signed [31:0]            best_similarity,
	output logic signed [31:0]            fitted_scale
);
	import kms_pkg::*;

	localparam int IDX_W = (KERNEL_COUNT > 1) ? $clog2(KERNEL_COUNT) : 1;
	localparam int CNT_W = $clog2(KERNEL_COUNT + 1);
	localparam int KMAX = KERNEL_COUNT - 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_NORM  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	elem_vec_t coef_mem [KERNEL_COUNT];
	logic [15:0] norm_mem [KERNEL_COUNT];
	elem_vec_t in_vec, patch_q, coef_rd;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] issued_q;
	logic [2:0] drain_q;
	logic rd_v_s1, rd_v_s2, rd_v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic signed [DOT_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0] norm_rd_q;
	logic signed [DOT_W+16:0] prod_q;
	logic signed [DOT_W+16:0] rnd;
	logic signed [DOT_W+1:0] shr;
	logic matched_q;
	logic accept;
	logic out_emit;

	assign in_vec = {elem_8, elem_7, elem_6, elem_5, elem_4, elem_3, elem_2, elem_1, elem_0};
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	// A finished result moves to the output once the previous beat there has left.
	assign out_emit = (state_q == ST_OUT) && (!out_valid || out_ready);

	// Load beats write one table row.
	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD && 32'(kernel_slot) < KERNEL_COUNT) begin
			coef_mem[IDX_W'(kernel_slot)] <= in_vec;
			norm_mem[IDX_W'(kernel_slot)] <= inverse_norm;
		end
	end

	// Synchronous reads: one kernel row per cycle, and the norm row at the current best index.
	always_ff @(posedge clk) begin
		coef_rd <= coef_mem[rd_idx_q];
		norm_rd_q <= norm_mem[best_idx_q];
	end

	kms_dot9 u_dot (.clk(clk), .patch(patch_q), .coef(coef_rd), .dot(dot_s3));

	// Rounding of the fitted scale; saturation is applied in the output state.
	always_comb begin
		rnd = prod_q + (DOT_W+17)'(16384);
		shr = (DOT_W+2)'(rnd >>> 15);
	end

	// Scan control and running best.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
			rd_v_s3 <= 1'b0;
			rd_idx_q <= '0;
			issued_q <= '0;
			drain_q <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			rd_v_s2 <= rd_v_s1;
			rd_v_s3 <= rd_v_s2;
			if (out_emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_QUERY) begin
						patch_q <= in_vec;
						rd_idx_q <= '0;
						issued_q <= '0;
						best_q <= '0;
						best_idx_q <= '0;
						if (elem_0[15]) begin
							// A skipped patch goes straight to the output with a zero result.
							matched_q <= 1'b0;
							prod_q <= '0;
							state_q <= ST_OUT;
						end else begin
							matched_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_s1 <= rd_idx_q;
					issued_q <= issued_q + 1'b1;
					if (32'(issued_q) == KMAX) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'd3) state_q <= ST_NORM;
				end
				ST_NORM: state_q <= ST_MUL;
				ST_MUL: begin
					prod_q <= (DOT_W+17)'(best_q) * (DOT_W+17)'($signed({1'b0, norm_rd_q}));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_emit) begin
						match_valid <= matched_q;
						best_kernel <= SLOT_W'({{SLOT_W{1'b0}}, best_idx_q});
						best_similarity <= (best_q > 37'sd2147483647) ? 32'sh7fffffff
							: 32'(best_q);
						if (shr > (DOT_W+2)'(64'sd2147483647)) fitted_scale <= 32'sh7fffffff;
						else if (shr < -(DOT_W+2)'(64'sd2147483648))
							fitted_scale <= 32'sh80000000;
						else fitted_scale <= 32'(shr);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			if (rd_v_s3 && dot_s3 > best_q) begin
				best_q <= dot_s3;
				best_idx_q <= idx_s3;
			end
		end
	end
endmodule
